>>> hw/rtl/weighted_priority_max_heap_top_defines.svh
// Assertion macros for the heap block. The design signals are clk and rst_n.
`ifndef WEIGHTED_PRIORITY_MAX_HEAP_TOP_DEFINES_SVH
`define WEIGHTED_PRIORITY_MAX_HEAP_TOP_DEFINES_SVH

`ifndef SYNTH
`define WPMH_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("heap assertion failed");
`define WPMH_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("heap assertion failed");
`else
`define WPMH_ASSERT_SAME(lbl, ante, cons)
`define WPMH_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

>>> hw/rtl/wpmh_pkg.sv
`default_nettype none
package wpmh_pkg;

  localparam int HEAP_SLOTS_DEF = 64;
  localparam int TAG_BITS_DEF   = 16;
  localparam int PRIO_W         = 40;

  localparam logic [7:0] W_BATTERY_RST     = 8'd2;
  localparam logic [7:0] W_WAIT_RST        = 8'd1;
  localparam logic [7:0] PREMIUM_BONUS_RST = 8'd50;

  localparam logic [1:0] CFG_W_BATTERY     = 2'd0;
  localparam logic [1:0] CFG_W_WAIT        = 2'd1;
  localparam logic [1:0] CFG_PREMIUM_BONUS = 2'd2;

  typedef enum logic [1:0] {
    CMD_INSERT  = 2'd0,
    CMD_EXTRACT = 2'd1,
    CMD_REBUILD = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    STS_DONE  = 2'd0,
    STS_FULL  = 2'd1,
    STS_EMPTY = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INS_P,
    S_UP,
    S_UP_LD,
    S_UP_CMP,
    S_EX_TOP,
    S_EX_LAST,
    S_DN_P,
    S_DN,
    S_DN_L,
    S_DN_R,
    S_DN_CMP,
    S_RB_LD,
    S_DONE
  } state_t;

  typedef struct packed {
    cmd_t        cmd;
    logic [15:0] entry_tag;
    logic [6:0]  battery_level;
    logic [31:0] arrival_time;
    logic        is_premium;
    logic [31:0] current_time;
  } in_item_t;

  typedef struct packed {
    status_t     status;
    logic [15:0] out_tag;
    logic [6:0]  out_battery;
    logic [31:0] out_arrival;
    logic        out_premium;
    logic [39:0] out_priority;
    logic [5:0]  entry_count;
  } out_item_t;

endpackage
`default_nettype wire

>>> hw/rtl/wpmh_ram.sv
`default_nettype none
module wpmh_ram #(
  parameter int WIDTH = 56,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

>>> hw/rtl/weighted_priority_max_heap_top.sv
// Channel  Direction  Handshake          Payload
// in       input      in_valid/in_stall  wpmh_pkg::in_item_t (cmd, entry, current_time)
// out      output     out_valid/out_stall wpmh_pkg::out_item_t (status, entry, count)
// cfg      input      cfg_valid/cfg_ready cfg_index, cfg_data (8-bit weights)
//
// One item at a time. Insert climbs level by level, each level a parent read,
// its priority and a compare; extract descends, each level a left read, a
// right read if any, a compare and the next read; rebuild loads each inner
// node in turn and sinks it likewise. The heap RAM's single registered read
// port sets these steps. Reset empties the heap through the count alone.
// The next item is accepted once the result is in the output register.
`default_nettype none
`include "weighted_priority_max_heap_top_defines.svh"
module weighted_priority_max_heap_top #(
  parameter int HEAP_SLOTS = wpmh_pkg::HEAP_SLOTS_DEF,
  parameter int TAG_BITS   = wpmh_pkg::TAG_BITS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire wpmh_pkg::in_item_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output wpmh_pkg::out_item_t      out_data,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [1:0]          cfg_index,
  input  wire logic [7:0]          cfg_data
);

  localparam int AW = $clog2(HEAP_SLOTS);
  localparam int EW = TAG_BITS + 40;
  localparam logic [AW-1:0] LAST_SLOT = AW'(HEAP_SLOTS - 1);
  localparam logic [AW-1:0] ROOT      = AW'(1);

  function automatic logic [39:0] prio_f(input logic [EW-1:0] e, input logic [31:0] now,
                                         input logic [7:0] wb, input logic [7:0] ww,
                                         input logic [7:0] bonus);
    logic [6:0]  bat;
    logic [6:0]  miss;
    logic [31:0] arr;
    logic [31:0] wt;
    bat  = e[39:33];
    arr  = e[32:1];
    miss = (bat >= 7'd100) ? 7'd0 : 7'd100 - bat;
    wt   = (now > arr) ? now - arr : 32'd0;
    return 40'(miss) * 40'(wb) + 40'(wt) * 40'(ww) + (e[0] ? 40'(bonus) : 40'd0);
  endfunction

  wpmh_pkg::state_t    state_r, state_nxt;
  wpmh_pkg::cmd_t      cmd_r, cmd_nxt;
  logic [AW-1:0]       count_r, count_nxt;
  logic [AW-1:0]       idx_r, idx_nxt;
  logic [AW-1:0]       rb_r, rb_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [7:0]          wb_r, ww_r, bonus_r;

  logic [31:0]         now_r, now_nxt;
  logic [EW-1:0]       cur_r, cur_nxt, ch_r, ch_nxt, rt_r, rt_nxt;
  logic [39:0]         cur_prio_r, cur_prio_nxt, ch_prio_r, ch_prio_nxt;
  logic [39:0]         rt_prio_r, rt_prio_nxt;
  logic                has_r_r, has_r_nxt;
  wpmh_pkg::out_item_t res_r, res_nxt, out_r, out_nxt;

  logic                ram_we;
  logic [AW-1:0]       ram_waddr, ram_raddr;
  logic [EW-1:0]       ram_wdata, ram_rdata;

  logic [EW-1:0]       pin;
  logic [39:0]         prio_w;
  logic [AW:0]         lidx, ridx, cnt_x;
  logic [AW+5:0]       cnt6;
  logic [TAG_BITS+15:0] tag_in_x, tag_out_x;
  logic                accept;
  logic                big_l, big_r;
  logic [39:0]         bigp;

  wpmh_ram #(.WIDTH(EW), .DEPTH(HEAP_SLOTS)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_stall  = (state_r != wpmh_pkg::S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign cfg_ready = 1'b1;

  assign lidx     = {idx_r, 1'b0};
  assign ridx     = lidx + (AW+1)'(1);
  assign cnt_x    = {1'b0, count_r};
  assign cnt6     = {6'b0, count_r};
  assign tag_in_x = {TAG_BITS'(0), in_data.entry_tag};
  assign tag_out_x = {16'b0, ram_rdata[EW-1:40]};

  // shared priority unit: RAM data in load states, else the sifting entry
  always_comb begin
    case (state_r)
      wpmh_pkg::S_UP_LD, wpmh_pkg::S_DN_L, wpmh_pkg::S_DN_R,
      wpmh_pkg::S_EX_TOP: pin = ram_rdata;
      default:            pin = cur_r;
    endcase
  end
  assign prio_w = prio_f(pin, now_r, wb_r, ww_r, bonus_r);

  assign big_l = ch_prio_r > cur_prio_r;
  assign bigp  = big_l ? ch_prio_r : cur_prio_r;
  assign big_r = has_r_r && (rt_prio_r > bigp);

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    rb_nxt        = rb_r;
    now_nxt       = now_r;
    cur_nxt       = cur_r;
    ch_nxt        = ch_r;
    rt_nxt        = rt_r;
    cur_prio_nxt  = cur_prio_r;
    ch_prio_nxt   = ch_prio_r;
    rt_prio_nxt   = rt_prio_r;
    has_r_nxt     = has_r_r;
    res_nxt       = res_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && out_stall;
    ram_we        = 1'b0;
    ram_waddr     = idx_r;
    ram_wdata     = cur_r;
    ram_raddr     = ROOT;

    case (state_r)
      wpmh_pkg::S_IDLE: begin
        if (accept) begin
          cmd_nxt = in_data.cmd;
          now_nxt = in_data.current_time;
          cur_nxt = {tag_in_x[TAG_BITS-1:0], in_data.battery_level,
                     in_data.arrival_time, in_data.is_premium};
          res_nxt = '0;
          state_nxt = wpmh_pkg::S_DONE;
          case (in_data.cmd)
            wpmh_pkg::CMD_INSERT: begin
              if (count_r == LAST_SLOT) begin
                res_nxt.status = wpmh_pkg::STS_FULL;
              end else begin
                count_nxt = count_r + AW'(1);
                idx_nxt   = count_r + AW'(1);
                state_nxt = wpmh_pkg::S_INS_P;
              end
            end
            wpmh_pkg::CMD_EXTRACT: begin
              if (count_r == '0) begin
                res_nxt.status = wpmh_pkg::STS_EMPTY;
              end else begin
                ram_raddr = ROOT;
                state_nxt = wpmh_pkg::S_EX_TOP;
              end
            end
            wpmh_pkg::CMD_REBUILD: begin
              if ((count_r >> 1) != '0) begin
                rb_nxt    = count_r >> 1;
                ram_raddr = count_r >> 1;
                state_nxt = wpmh_pkg::S_RB_LD;
              end
            end
            default: ;
          endcase
        end
      end
      wpmh_pkg::S_INS_P: begin
        cur_prio_nxt = prio_w;
        state_nxt    = wpmh_pkg::S_UP;
      end
      wpmh_pkg::S_UP: begin
        if (idx_r == ROOT) begin
          ram_we    = 1'b1;
          state_nxt = wpmh_pkg::S_DONE;
        end else begin
          ram_raddr = idx_r >> 1;
          state_nxt = wpmh_pkg::S_UP_LD;
        end
      end
      wpmh_pkg::S_UP_LD: begin
        ch_nxt      = ram_rdata;
        ch_prio_nxt = prio_w;
        state_nxt   = wpmh_pkg::S_UP_CMP;
      end
      wpmh_pkg::S_UP_CMP: begin
        ram_we = 1'b1;
        if (cur_prio_r > ch_prio_r) begin
          ram_wdata = ch_r;
          idx_nxt   = idx_r >> 1;
          state_nxt = wpmh_pkg::S_UP;
        end else begin
          state_nxt = wpmh_pkg::S_DONE;
        end
      end
      wpmh_pkg::S_EX_TOP: begin
        res_nxt.out_tag      = tag_out_x[15:0];
        res_nxt.out_battery  = ram_rdata[39:33];
        res_nxt.out_arrival  = ram_rdata[32:1];
        res_nxt.out_premium  = ram_rdata[0];
        res_nxt.out_priority = prio_w;
        ram_raddr = count_r;
        state_nxt = wpmh_pkg::S_EX_LAST;
      end
      wpmh_pkg::S_EX_LAST: begin
        cur_nxt   = ram_rdata;
        count_nxt = count_r - AW'(1);
        idx_nxt   = ROOT;
        state_nxt = (count_r == ROOT) ? wpmh_pkg::S_DONE : wpmh_pkg::S_DN_P;
      end
      wpmh_pkg::S_RB_LD: begin
        cur_nxt   = ram_rdata;
        idx_nxt   = rb_r;
        state_nxt = wpmh_pkg::S_DN_P;
      end
      wpmh_pkg::S_DN_P: begin
        cur_prio_nxt = prio_w;
        state_nxt    = wpmh_pkg::S_DN;
      end
      wpmh_pkg::S_DN: begin
        if (lidx > cnt_x) begin
          // leaf reached: settle the entry, then the next rebuild node if any
          ram_we = 1'b1;
          if (cmd_r == wpmh_pkg::CMD_REBUILD && rb_r > ROOT) begin
            rb_nxt    = rb_r - AW'(1);
            ram_raddr = rb_r - AW'(1);
            state_nxt = wpmh_pkg::S_RB_LD;
          end else begin
            state_nxt = wpmh_pkg::S_DONE;
          end
        end else begin
          ram_raddr = lidx[AW-1:0];
          state_nxt = wpmh_pkg::S_DN_L;
        end
      end
      wpmh_pkg::S_DN_L: begin
        ch_nxt      = ram_rdata;
        ch_prio_nxt = prio_w;
        has_r_nxt   = ridx <= cnt_x;
        if (ridx <= cnt_x) begin
          ram_raddr = ridx[AW-1:0];
          state_nxt = wpmh_pkg::S_DN_R;
        end else begin
          state_nxt = wpmh_pkg::S_DN_CMP;
        end
      end
      wpmh_pkg::S_DN_R: begin
        rt_nxt      = ram_rdata;
        rt_prio_nxt = prio_w;
        state_nxt   = wpmh_pkg::S_DN_CMP;
      end
      wpmh_pkg::S_DN_CMP: begin
        ram_we = 1'b1;
        if (big_r) begin
          ram_wdata = rt_r;
          idx_nxt   = ridx[AW-1:0];
          state_nxt = wpmh_pkg::S_DN;
        end else if (big_l) begin
          ram_wdata = ch_r;
          idx_nxt   = lidx[AW-1:0];
          state_nxt = wpmh_pkg::S_DN;
        end else if (cmd_r == wpmh_pkg::CMD_REBUILD && rb_r > ROOT) begin
          rb_nxt    = rb_r - AW'(1);
          ram_raddr = rb_r - AW'(1);
          state_nxt = wpmh_pkg::S_RB_LD;
        end else begin
          state_nxt = wpmh_pkg::S_DONE;
        end
      end
      wpmh_pkg::S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_nxt             = res_r;
          out_nxt.entry_count = cnt6[5:0];
          out_valid_nxt       = 1'b1;
          state_nxt           = wpmh_pkg::S_IDLE;
        end
      end
      default: state_nxt = wpmh_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= wpmh_pkg::S_IDLE;
      cmd_r       <= wpmh_pkg::CMD_INSERT;
      count_r     <= '0;
      idx_r       <= '0;
      rb_r        <= '0;
      out_valid_r <= 1'b0;
      wb_r        <= wpmh_pkg::W_BATTERY_RST;
      ww_r        <= wpmh_pkg::W_WAIT_RST;
      bonus_r     <= wpmh_pkg::PREMIUM_BONUS_RST;
    end else begin
      state_r     <= state_nxt;
      cmd_r       <= cmd_nxt;
      count_r     <= count_nxt;
      idx_r       <= idx_nxt;
      rb_r        <= rb_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          wpmh_pkg::CFG_W_BATTERY:     wb_r    <= cfg_data;
          wpmh_pkg::CFG_W_WAIT:        ww_r    <= cfg_data;
          wpmh_pkg::CFG_PREMIUM_BONUS: bonus_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    now_r      <= now_nxt;
    cur_r      <= cur_nxt;
    ch_r       <= ch_nxt;
    rt_r       <= rt_nxt;
    cur_prio_r <= cur_prio_nxt;
    ch_prio_r  <= ch_prio_nxt;
    rt_prio_r  <= rt_prio_nxt;
    has_r_r    <= has_r_nxt;
    res_r      <= res_nxt;
    out_r      <= out_nxt;
  end

  `WPMH_ASSERT_NEXT(a_busy_after_accept, accept, in_stall)
  `WPMH_ASSERT_SAME(a_count_bound, 1'b1, count_r <= LAST_SLOT)
  `WPMH_ASSERT_SAME(a_extract_nonempty, state_r == wpmh_pkg::S_EX_TOP, count_r != '0)
  `WPMH_ASSERT_SAME(a_write_in_heap, ram_we, (ram_waddr != '0) && (ram_waddr <= count_r))

endmodule
`default_nettype wire

>>> test/weighted_priority_max_heap_top_test.sv
`default_nettype none
module weighted_priority_max_heap_top_test;

  localparam int SLOTS = wpmh_pkg::HEAP_SLOTS_DEF;
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int STALL_PCT = 31;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int SETTLE_CYCLES = 40;

  typedef struct {
    logic [15:0] tag;
    logic [6:0]  battery;
    logic [31:0] arrival;
    logic        premium;
  } slot_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  wpmh_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  wpmh_pkg::out_item_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [7:0] cfg_data = '0;

  weighted_priority_max_heap_top u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  // model of the heap
  slot_t heap_q[SLOTS];
  int unsigned heap_cnt;
  logic [7:0] wt_battery, wt_wait, bonus;

  wpmh_pkg::out_item_t result_q[$];
  int unsigned fail_cnt;
  bit no_idle;
  int unsigned hold_left;
  logic [31:0] now_t;

  function automatic logic [39:0] priority_at(slot_t s, logic [31:0] now);
    logic [39:0] missing, waited, p;
    missing = (s.battery >= 7'd100) ? 40'd0 : 40'(7'd100 - s.battery);
    waited = (now > s.arrival) ? 40'(now - s.arrival) : 40'd0;
    p = missing * wt_battery + waited * wt_wait;
    if (s.premium) p = p + bonus;
    return p;
  endfunction

  task automatic swap_slots(int unsigned a, int unsigned b);
    slot_t t;
    t = heap_q[a];
    heap_q[a] = heap_q[b];
    heap_q[b] = t;
  endtask

  task automatic sift_down(int unsigned start, logic [31:0] now);
    int unsigned i, l, r, big;
    i = start;
    forever begin
      l = 2 * i;
      r = 2 * i + 1;
      big = i;
      if (l <= heap_cnt && l < SLOTS &&
          priority_at(heap_q[l], now) > priority_at(heap_q[big], now)) big = l;
      if (r <= heap_cnt && r < SLOTS &&
          priority_at(heap_q[r], now) > priority_at(heap_q[big], now)) big = r;
      if (big == i) break;
      swap_slots(i, big);
      i = big;
    end
  endtask

  task automatic predict_command(wpmh_pkg::in_item_t it);
    wpmh_pkg::out_item_t res;
    slot_t top;
    int unsigned i;
    res = '0;
    case (logic'(1'b1))
      it.cmd == wpmh_pkg::CMD_INSERT: begin
        if (heap_cnt + 1 >= SLOTS) begin
          res.status = wpmh_pkg::STS_FULL;
        end else begin
          heap_cnt++;
          i = heap_cnt;
          heap_q[i] = '{it.entry_tag, it.battery_level, it.arrival_time, it.is_premium};
          while (i > 1 && priority_at(heap_q[i], it.current_time) >
                          priority_at(heap_q[i / 2], it.current_time)) begin
            swap_slots(i, i / 2);
            i = i / 2;
          end
        end
      end
      it.cmd == wpmh_pkg::CMD_EXTRACT: begin
        if (heap_cnt == 0) begin
          res.status = wpmh_pkg::STS_EMPTY;
        end else begin
          top = heap_q[1];
          res.out_tag = top.tag;
          res.out_battery = top.battery;
          res.out_arrival = top.arrival;
          res.out_premium = top.premium;
          res.out_priority = priority_at(top, it.current_time);
          heap_q[1] = heap_q[heap_cnt];
          heap_cnt--;
          sift_down(1, it.current_time);
        end
      end
      it.cmd == wpmh_pkg::CMD_REBUILD: begin
        for (i = heap_cnt / 2; i >= 1; i--) sift_down(i, it.current_time);
      end
      default: ;
    endcase
    res.entry_count = 6'(heap_cnt);
    result_q.push_back(res);
  endtask

  task automatic send_item(wpmh_pkg::in_item_t it);
    @(negedge clk);
    while (!no_idle && $urandom_range(99) < STALL_PCT) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data = it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_command(it);
  endtask

  task automatic drain;
    @(negedge clk);
    in_valid = 1'b0;
    while (result_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [7:0] val);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      wpmh_pkg::CFG_W_BATTERY: wt_battery = val;
      wpmh_pkg::CFG_W_WAIT: wt_wait = val;
      default: bonus = val;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic set_weights(logic [7:0] wb, logic [7:0] ww, logic [7:0] pb);
    write_reg(wpmh_pkg::CFG_W_BATTERY, wb);
    write_reg(wpmh_pkg::CFG_W_WAIT, ww);
    write_reg(wpmh_pkg::CFG_PREMIUM_BONUS, pb);
  endtask

  function automatic wpmh_pkg::in_item_t make_cmd(logic [1:0] c, logic [31:0] now);
    wpmh_pkg::in_item_t it;
    it = '0;
    it.cmd = wpmh_pkg::cmd_t'(c);
    it.current_time = now;
    return it;
  endfunction

  function automatic wpmh_pkg::in_item_t make_insert(logic [15:0] tag, logic [6:0] bat,
                                                     logic [31:0] arr, logic prem,
                                                     logic [31:0] now);
    wpmh_pkg::in_item_t it;
    it = make_cmd(wpmh_pkg::CMD_INSERT, now);
    it.entry_tag = tag;
    it.battery_level = bat;
    it.arrival_time = arr;
    it.is_premium = prem;
    return it;
  endfunction

  function automatic wpmh_pkg::in_item_t random_insert();
    logic [6:0] bat;
    logic [31:0] arr;
    bat = ($urandom_range(9) == 0) ? 7'($urandom_range(127, 101)) : 7'($urandom_range(100));
    case ($urandom_range(9))
      0: arr = $urandom;
      1: arr = now_t + $urandom_range(1, 500);
      default: arr = now_t - $urandom_range(0, 2000);
    endcase
    return make_insert(16'($urandom), bat, arr, 1'($urandom), now_t);
  endfunction

  function automatic wpmh_pkg::in_item_t random_command();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 3) return make_cmd(CMD_UNUSED, now_t);
    if (roll < 8) return make_cmd(wpmh_pkg::CMD_REBUILD, now_t);
    if (heap_cnt < 8 ? roll < 75 : roll < 52) return random_insert();
    return make_cmd(wpmh_pkg::CMD_EXTRACT, now_t);
  endfunction

  task automatic advance_time();
    if ($urandom_range(49) == 0) now_t = $urandom;
    else now_t = now_t + $urandom_range(0, 60);
  endtask

  task automatic test_directed;
    now_t = 32'd1000;
    send_item(make_cmd(wpmh_pkg::CMD_EXTRACT, now_t));
    send_item(make_cmd(wpmh_pkg::CMD_REBUILD, now_t));
    send_item(make_cmd(CMD_UNUSED, now_t));
    send_item(make_insert(16'hFFFF, 7'd0, 32'd0, 1'b1, now_t));
    send_item(make_insert(16'h0000, 7'd100, 32'd1000, 1'b0, now_t));
    send_item(make_insert(16'h1234, 7'd127, 32'hFFFF_FFFF, 1'b1, now_t));
    send_item(make_insert(16'h5555, 7'd50, 32'd1500, 1'b0, now_t));
    send_item(make_insert(16'hAAAA, 7'd50, 32'd1500, 1'b0, now_t));
    send_item(make_cmd(wpmh_pkg::CMD_REBUILD, 32'hFFFF_FFFF));
    send_item(make_cmd(CMD_UNUSED, now_t));
    repeat (6) send_item(make_cmd(wpmh_pkg::CMD_EXTRACT, 32'hFFFF_FFFF));
    drain();
  endtask

  task automatic test_full_heap;
    now_t = 32'h8000_0000;
    repeat (SLOTS + 1) begin
      advance_time();
      send_item(random_insert());
    end
    send_item(make_cmd(wpmh_pkg::CMD_REBUILD, now_t + 32'd5000));
    drain();
  endtask

  task automatic test_backpressure;
    hold_left = 300;
    no_idle = 1'b1;
    repeat (12) send_item(make_cmd(wpmh_pkg::CMD_EXTRACT, now_t));
    no_idle = 1'b0;
    drain();
  endtask

  task automatic test_random;
    for (int unsigned seg = 0; seg < 10; seg++) begin
      case (seg)
        0: set_weights(8'd0, 8'd0, 8'd0);
        1: set_weights(8'd255, 8'd255, 8'd255);
        2: set_weights(8'd255, 8'd0, 8'd0);
        3: set_weights(8'd0, 8'd255, 8'd0);
        default: set_weights(8'($urandom), 8'($urandom), 8'($urandom));
      endcase
      no_idle = (seg == 4);
      repeat (90) begin
        advance_time();
        send_item(random_command());
      end
      no_idle = 1'b0;
      drain();
    end
  endtask

  // receiver stall generator
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else begin
      out_stall <= !no_idle && ($urandom_range(99) < STALL_PCT);
    end
  end

  always @(posedge clk) begin
    wpmh_pkg::out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (result_q.size() == 0) begin
        $error("unexpected result: status %0d", out_data.status);
        fail_cnt++;
      end else begin
        want = result_q.pop_front();
        if (out_data.status != want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_data.status); fail_cnt++;
        end
        if (out_data.out_tag != want.out_tag) begin
          $error("out_tag: expected %h, got %h", want.out_tag, out_data.out_tag); fail_cnt++;
        end
        if (out_data.out_battery != want.out_battery) begin
          $error("out_battery: expected %0d, got %0d", want.out_battery,
                 out_data.out_battery);
          fail_cnt++;
        end
        if (out_data.out_arrival != want.out_arrival) begin
          $error("out_arrival: expected %h, got %h", want.out_arrival,
                 out_data.out_arrival);
          fail_cnt++;
        end
        if (out_data.out_premium != want.out_premium) begin
          $error("out_premium: expected %b, got %b", want.out_premium,
                 out_data.out_premium);
          fail_cnt++;
        end
        if (out_data.out_priority != want.out_priority) begin
          $error("out_priority: expected %0d, got %0d", want.out_priority,
                 out_data.out_priority);
          fail_cnt++;
        end
        if (out_data.entry_count != want.entry_count) begin
          $error("entry_count: expected %0d, got %0d", want.entry_count,
                 out_data.entry_count);
          fail_cnt++;
        end
      end
    end
  end

  // no item moving for too long means the block hung
  int unsigned quiet_cycles = 0;
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    heap_cnt = 0;
    fail_cnt = 0;
    no_idle = 1'b0;
    hold_left = 0;
    now_t = '0;
    wt_battery = wpmh_pkg::W_BATTERY_RST;
    wt_wait = wpmh_pkg::W_WAIT_RST;
    bonus = wpmh_pkg::PREMIUM_BONUS_RST;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_directed();
    test_full_heap();
    test_backpressure();
    test_random();
    set_weights(8'd0, 8'd255, 8'd255);
    test_full_heap();
    repeat (70) send_item(make_cmd(wpmh_pkg::CMD_EXTRACT, now_t));
    drain();
    if (fail_cnt == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end
endmodule
`default_nettype wire
